>>> design/tmcbf_pkg.sv
// Shared types, constants and pixel helpers for the mip chain box filter.
package tmcbf_pkg;

  localparam int MAX_DIM_DEF    = 1024;
  localparam int MAX_LEVELS_DEF = 11;

  localparam int CFG_AW   = 4;
  localparam int DIM_W    = 11;
  localparam int LVL_W    = 4;
  localparam int POS_W    = 10;
  localparam int PIX_W    = 32;
  localparam int SUM_W    = 36;
  localparam int OUT_DW   = 56;

  // register indexes (byte address bits 3:2)
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_MIP_EN = 2'd2;

  typedef struct packed {
    logic load;
    logic eval;
    logic step;
    logic fin;
  } cmd_t;

  typedef struct packed {
    logic go;
    logic left_only;
    logic store_only;
    logic slot_free;
  } sts_t;

  function automatic logic [PIX_W-1:0] swap_red_blue(input logic [PIX_W-1:0] p);
    return {p[31:24], p[7:0], p[15:8], p[23:16]};
  endfunction

  function automatic logic [SUM_W-1:0] spread_lanes(input logic [PIX_W-1:0] p);
    return {1'b0, p[31:24], 1'b0, p[23:16], 1'b0, p[15:8], 1'b0, p[7:0]};
  endfunction

  function automatic logic [PIX_W-1:0] block_average(input logic [SUM_W-1:0] up,
                                                     input logic [SUM_W-1:0] lo);
    logic [PIX_W-1:0] res;
    logic [9:0]       s;
    res = '0;
    for (int k = 0; k < 4; k++) begin
      s = {1'b0, up[9*k +: 9]} + {1'b0, lo[9*k +: 9]};
      res[8*k +: 8] = s[9:2];
    end
    return res;
  endfunction

endpackage

>>> design/texture_mip_chain_box_filter.sv
// Top level of the mip chain builder: APB registers, sequencer and datapath.
// Flow: an accepted request is loaded, then each level is evaluated and its result
// is registered when the result slot is free; a new request is taken only once the
// serial walk down the coarser levels is finished, and the pair row store is read
// through a register.
// Reset: rst_ni clears the sequencer, output valid and all level counters;
// the pair store and held left pixels start undefined and are written first.
module texture_mip_chain_box_filter #(
  parameter int MAX_DIM    = tmcbf_pkg::MAX_DIM_DEF,
  parameter int MAX_LEVELS = tmcbf_pkg::MAX_LEVELS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [tmcbf_pkg::PIX_W-1:0]   s_axis_tdata_i,   // source_pixel
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // mip_level[3:0], pixel_column[13:4], pixel_row[23:14], out_pixel[55:24]
  output logic [tmcbf_pkg::OUT_DW-1:0]  m_axis_tdata_o,
  output logic                          m_axis_tlast_o,   // last_of_run
  output logic                          m_axis_tuser_o,   // frame_done
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tmcbf_pkg::CFG_AW-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import tmcbf_pkg::*;

  logic [DIM_W-1:0] width_q, height_q;
  logic             mip_en_q;
  logic             cfg_wr, cfg_hit;
  logic [1:0]       reg_idx;
  cmd_t             cmd;
  sts_t             sts;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;
  // any write to a listed register restarts the frame
  assign cfg_hit = cfg_wr && (reg_idx == REG_WIDTH || reg_idx == REG_HEIGHT ||
                              reg_idx == REG_MIP_EN);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DIM_W'(1);
      height_q <= DIM_W'(1);
      mip_en_q <= 1'b0;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_WIDTH:  width_q  <= pwdata[DIM_W-1:0];
        REG_HEIGHT: height_q <= pwdata[DIM_W-1:0];
        REG_MIP_EN: mip_en_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_WIDTH:  prdata = 32'(width_q);
      REG_HEIGHT: prdata = 32'(height_q);
      REG_MIP_EN: prdata = 32'(mip_en_q);
      default:    prdata = '0;
    endcase
  end

  // sequencer: one request and its level cascade at a time
  tmcbf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath: counters, pair store, averaging, result register
  tmcbf_dp #(
    .MAX_DIM    (MAX_DIM),
    .MAX_LEVELS (MAX_LEVELS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .clear_i     (cfg_hit),
    .width_i     (width_q),
    .height_i    (height_q),
    .mip_en_i    (mip_en_q),
    .pix_i       (s_axis_tdata_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o),
    .out_last_o  (m_axis_tlast_o),
    .out_done_o  (m_axis_tuser_o)
  );

endmodule

>>> design/tmcbf_ctrl.sv
// Sequencer for one input pixel and its cascade through the mip levels.
module tmcbf_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  tmcbf_pkg::sts_t sts_i,
  output tmcbf_pkg::cmd_t cmd_o
);
  import tmcbf_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_EVAL, S_AVG, S_FIN} state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd_o.eval = 1'b1;
        if (!sts_i.go || sts_i.left_only || sts_i.store_only) begin
          state_d = S_FIN;
        end else begin
          state_d = S_AVG;
        end
      end
      S_AVG: begin
        if (sts_i.slot_free) begin
          cmd_o.step = 1'b1;
          state_d    = S_EVAL;
        end
      end
      S_FIN: begin
        if (sts_i.slot_free) begin
          cmd_o.fin = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> design/tmcbf_dp.sv
// Datapath: level counters, pair store, block averaging and result registers.
module tmcbf_dp #(
  parameter int MAX_DIM    = tmcbf_pkg::MAX_DIM_DEF,
  parameter int MAX_LEVELS = tmcbf_pkg::MAX_LEVELS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  tmcbf_pkg::cmd_t                cmd_i,
  output tmcbf_pkg::sts_t                sts_o,
  input  logic                           clear_i,
  input  logic [tmcbf_pkg::DIM_W-1:0]    width_i,
  input  logic [tmcbf_pkg::DIM_W-1:0]    height_i,
  input  logic                           mip_en_i,
  input  logic [tmcbf_pkg::PIX_W-1:0]    pix_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [tmcbf_pkg::OUT_DW-1:0]   out_data_o,
  output logic                           out_last_o,
  output logic                           out_done_o
);
  import tmcbf_pkg::*;

  localparam int CW   = $clog2(MAX_DIM);
  localparam int DW   = $clog2(MAX_DIM + 1);
  localparam int BW   = DW + 1;
  localparam int AW   = $clog2(MAX_DIM);
  localparam int LW   = $clog2(MAX_LEVELS + 1);
  localparam int IW   = $clog2(MAX_LEVELS);
  localparam int CMPW = (DW > DIM_W) ? DW : DIM_W;

  logic [PIX_W-1:0] cur_q;
  logic [CW-1:0]    c_q, r_q;
  logic [DW-1:0]    wf_q, hf_q;
  logic [LW-1:0]    lvl_q;
  logic [BW-1:0]    base_q;
  logic             fend_q;
  logic [SUM_W-1:0] pair_q, mem_q;
  logic             self_q, rd_ok_q;

  logic [CW-1:0]    col_cnt_q [MAX_LEVELS];
  logic [CW-1:0]    row_cnt_q [MAX_LEVELS];
  logic [PIX_W-1:0] left_q    [MAX_LEVELS];
  logic [SUM_W-1:0] mem       [MAX_DIM];

  logic [OUT_DW-1:0] pend_q, out_q;
  logic              out_valid_q, out_last_q, out_done_q;

  // clamp of the configured size
  logic [CMPW-1:0] rw, rh;
  logic [DW-1:0]   wclamp, hclamp;
  assign rw = CMPW'(width_i);
  assign rh = CMPW'(height_i);
  assign wclamp = (rw == '0) ? DW'(1) : (rw > CMPW'(MAX_DIM)) ? DW'(MAX_DIM) : DW'(rw);
  assign hclamp = (rh == '0) ? DW'(1) : (rh > CMPW'(MAX_DIM)) ? DW'(MAX_DIM) : DW'(rh);

  // next level evaluation
  logic [LW-1:0]    nl;
  logic [IW-1:0]    nl_i;
  logic [DW-1:0]    wc, hc;
  logic [DW:0]      c_x, r_x;
  logic             w_big, h_big;
  logic [SUM_W-1:0] pair;
  logic [CW-1:0]    cc;
  logic [BW-1:0]    idx, region;

  assign nl    = lvl_q + LW'(1);
  assign nl_i  = IW'(nl);
  assign w_big = wf_q > DW'(1);
  assign h_big = hf_q > DW'(1);
  assign wc    = w_big ? (wf_q >> 1) : DW'(1);
  assign hc    = h_big ? (hf_q >> 1) : DW'(1);
  assign c_x   = (DW+1)'(c_q);
  assign r_x   = (DW+1)'(r_q);
  assign pair  = w_big ? (spread_lanes(left_q[nl_i]) + spread_lanes(cur_q))
                       : (spread_lanes(cur_q) << 1);
  assign cc    = w_big ? (c_q >> 1) : '0;
  assign idx   = base_q + BW'(cc);
  assign region = (BW'(MAX_DIM >> nl) == '0) ? BW'(1) : BW'(MAX_DIM >> nl);

  assign sts_o.go = mip_en_i && (nl < LW'(MAX_LEVELS)) && (w_big || h_big) &&
                    !(h_big && (r_x >= {hc, 1'b0})) &&
                    !(w_big && (c_x >= {wc, 1'b0}));
  assign sts_o.left_only  = w_big && !c_q[0];
  assign sts_o.store_only = h_big && !r_q[0];
  assign sts_o.slot_free  = !out_valid_q || out_ready_i;

  logic in_range, mem_we;
  assign in_range = idx < BW'(MAX_DIM);
  assign mem_we   = cmd_i.eval && sts_o.go && !sts_o.left_only && sts_o.store_only &&
                    in_range;

  // averaged pixel of the block
  logic [SUM_W-1:0] upper;
  logic [PIX_W-1:0] npix;
  assign upper = self_q ? pair_q : (rd_ok_q ? mem_q : '0);
  assign npix  = block_average(upper, pair_q);

  // counter update for level 0 on load, next level on step
  logic [IW-1:0] u_i;
  logic [CW-1:0] u_col, u_row;
  logic [DW-1:0] u_wl, u_hl, u_c1, u_r1;
  logic          u_wrap, u_fend;
  assign u_i    = cmd_i.load ? '0 : nl_i;
  assign u_col  = col_cnt_q[u_i];
  assign u_row  = row_cnt_q[u_i];
  assign u_wl   = cmd_i.load ? wclamp : wc;
  assign u_hl   = cmd_i.load ? hclamp : hc;
  assign u_c1   = DW'(u_col) + DW'(1);
  assign u_r1   = DW'(u_row) + DW'(1);
  assign u_wrap = u_c1 >= u_wl;
  assign u_fend = u_wrap && (u_r1 >= u_hl);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_LEVELS; i++) begin
        col_cnt_q[i] <= '0;
        row_cnt_q[i] <= '0;
      end
    end else if (clear_i || (cmd_i.fin && fend_q)) begin
      for (int i = 0; i < MAX_LEVELS; i++) begin
        col_cnt_q[i] <= '0;
        row_cnt_q[i] <= '0;
      end
    end else if (cmd_i.load || cmd_i.step) begin
      col_cnt_q[u_i] <= u_wrap ? '0 : CW'(u_c1);
      if (u_wrap) begin
        row_cnt_q[u_i] <= u_fend ? '0 : CW'(u_r1);
      end
    end
  end

  // working registers of the cascade
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cur_q  <= swap_red_blue(pix_i);
      c_q    <= col_cnt_q[0];
      r_q    <= row_cnt_q[0];
      wf_q   <= wclamp;
      hf_q   <= hclamp;
      lvl_q  <= '0;
      base_q <= '0;
      fend_q <= u_fend;
      pend_q <= {swap_red_blue(pix_i), POS_W'(row_cnt_q[0]), POS_W'(col_cnt_q[0]),
                 LVL_W'(0)};
    end else if (cmd_i.step) begin
      cur_q  <= npix;
      c_q    <= u_col;
      r_q    <= u_row;
      wf_q   <= wc;
      hf_q   <= hc;
      lvl_q  <= nl;
      base_q <= base_q + region;
      pend_q <= {npix, POS_W'(u_row), POS_W'(u_col), LVL_W'(nl)};
    end
    if (cmd_i.eval) begin
      pair_q  <= pair;
      self_q  <= !h_big;
      rd_ok_q <= in_range;
      if (sts_o.go && sts_o.left_only) begin
        left_q[nl_i] <= cur_q;
      end
    end
  end

  // pair row store, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[idx[AW-1:0]] <= pair;
    end
    if (cmd_i.eval) begin
      mem_q <= mem[idx[AW-1:0]];
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.step || cmd_i.fin) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step || cmd_i.fin) begin
      out_q      <= pend_q;
      out_last_q <= cmd_i.fin;
      out_done_q <= cmd_i.fin && fend_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign out_last_o  = out_last_q;
  assign out_done_o  = out_done_q;

endmodule

>>> design/tmcbf_checker.sv
// Port-level checks for the mip chain builder, bound to the top level.
module tmcbf_port_props #(
  parameter int MAX_LEVELS = tmcbf_pkg::MAX_LEVELS_DEF
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid_i,
  input logic                          s_axis_tready_o,
  input logic                          m_axis_tvalid_o,
  input logic                          m_axis_tready_i,
  input logic [tmcbf_pkg::OUT_DW-1:0]  m_axis_tdata_o,
  input logic                          m_axis_tlast_o,
  input logic                          m_axis_tuser_o
);
  import tmcbf_pkg::*;

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("stalled result changed");

  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tlast_o)
    else $error("frame end without run end");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("request taken while busy");

  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (32'(m_axis_tdata_o[LVL_W-1:0]) < MAX_LEVELS))
    else $error("level out of range");

endmodule

bind texture_mip_chain_box_filter tmcbf_port_props #(.MAX_LEVELS(MAX_LEVELS)) u_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);
